>>> rtl/bounded_stack_ordered_insert_top_assert.svh
// Assertion macros shared by the stack RTL.
`ifndef BOUNDED_STACK_ORDERED_INSERT_TOP_ASSERT_SVH
`define BOUNDED_STACK_ORDERED_INSERT_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define BSOI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);
`define BSOI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define BSOI_ASSERT(lbl, clk, rst_n, prop, msg)
`define BSOI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/bsoi_pkg.sv
package bsoi_pkg;

    localparam int DataW = 32;
    localparam int KindW = 3;
    localparam int StatW = 2;
    localparam int FillW = 5;
    localparam int CapW  = 5;

    localparam logic [CapW-1:0]  CapReset  = 5'd16;
    localparam logic [DataW-1:0] EmptyWord = 32'hFFFF_FFFF;

    // Register index taken from paddr[2].
    localparam logic RegCapacity = 1'b0;

    typedef enum logic [KindW-1:0] {
        K_PUSH    = 3'd0,
        K_POP     = 3'd1,
        K_PEEK    = 3'd2,
        K_INSERT  = 3'd3,
        K_REVERSE = 3'd4,
        K_SORT    = 3'd5
    } t_kind;

    typedef enum logic [StatW-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP,
        S_INS,
        S_SRT_RD,
        S_SRT_LD,
        S_REV_B,
        S_REV_C,
        S_REV_D,
        S_FIN
    } t_state;

    function automatic logic word_gt(input logic [DataW-1:0] a, input logic [DataW-1:0] b);
        return $signed(a) > $signed(b);
    endfunction

endpackage

>>> rtl/bsoi_ram.sv
module bsoi_ram import bsoi_pkg::*; #(
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [DataW-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [DataW-1:0] o_rdata
);

    logic [DataW-1:0] r_mem [DEPTH];
    logic [DataW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/bounded_stack_ordered_insert_top.sv
// Push and unused codes go from acceptance straight to the finish state, which loads the result.
// Pop and peek pass through a read state first; on an empty stack they go straight to finish.
// Ordered insert walks the hole down one entry per insert step, past each entry the value exceeds.
// Reverse swaps pairs through S_REV_B, S_REV_C and S_REV_D; sort runs read, load and insert
// for every entry above the bottom. A result becomes valid as tready returns; a held result stalls.
// Synchronous active-low reset empties the stack and sets capacity to 16; memory is not cleared.
`include "bounded_stack_ordered_insert_top_assert.svh"

module bounded_stack_ordered_insert_top import bsoi_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [2:0]  s_axis_tuser,   // [2:0] kind
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] data, [36:32] fill, [39:37] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam int UW = (LW > CapW) ? LW : CapW;
    localparam logic [LW-1:0] One = LW'(1);
    localparam logic [LW-1:0] Two = LW'(2);

    t_state           r_state, n_state;
    logic [LW-1:0]    r_level, n_level;
    logic [LW-1:0]    r_pos, n_pos;
    logic [LW-1:0]    r_lo, n_lo;
    logic [DataW-1:0] r_val, n_val;
    logic             r_full, n_full;
    logic             r_sort, n_sort;
    logic             r_pop, n_pop;
    logic [DataW-1:0] r_res_data, n_res_data;
    t_status          r_res_status, n_res_status;
    logic             r_out_valid, n_out_valid;
    logic [DataW-1:0] r_out_data, n_out_data;
    t_status          r_out_status, n_out_status;
    logic [FillW-1:0] r_out_fill, n_out_fill;
    logic [CapW-1:0]  r_cap;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [DataW-1:0] ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [DataW-1:0] ram_rdata;

    logic acc;
    logic out_free;
    logic full_now;
    logic gt;
    logic ins_stop;
    logic top_drop;

    bsoi_ram #(.DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Configuration
    assign pready = 1'b1;
    assign prdata = (paddr[2] == RegCapacity) ? {{(32-CapW){1'b0}}, r_cap} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CapReset;
        end else if (psel && penable && pwrite && pready && (paddr[2] == RegCapacity)) begin
            r_cap <= pwdata[CapW-1:0];
        end
    end

    assign acc      = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;
    assign full_now = (UW'(r_level) >= UW'(r_cap)) || (UW'(r_level) >= UW'(DEPTH));
    assign gt       = word_gt(r_val, ram_rdata);
    assign ins_stop = (r_pos == '0) || !gt;
    // On a full stack the hole starts one past the top, so nothing lands there.
    assign top_drop = r_full && (r_pos == r_level);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_fill, r_out_data};
    assign m_axis_tuser  = r_out_status;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (s_axis_tuser)
                        K_POP, K_PEEK: n_state = (r_level == '0) ? S_FIN : S_POP;
                        K_INSERT:      n_state = S_INS;
                        K_REVERSE:     n_state = (r_level > One) ? S_REV_B : S_FIN;
                        K_SORT:        n_state = (r_level > One) ? S_SRT_RD : S_FIN;
                        default:       n_state = S_FIN;
                    endcase
                end
            end
            S_POP: n_state = S_FIN;
            S_INS: begin
                if (ins_stop) begin
                    n_state = (r_sort && ((r_lo + One) < r_level)) ? S_SRT_RD : S_FIN;
                end
            end
            S_SRT_RD: n_state = S_SRT_LD;
            S_SRT_LD: n_state = S_INS;
            S_REV_B:  n_state = S_REV_C;
            S_REV_C:  n_state = S_REV_D;
            S_REV_D:  n_state = ((r_pos - One) > (r_lo + Two)) ? S_REV_B : S_FIN;
            S_FIN:    n_state = out_free ? S_IDLE : S_FIN;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_level      = r_level;
        n_pos        = r_pos;
        n_lo         = r_lo;
        n_val        = r_val;
        n_full       = r_full;
        n_sort       = r_sort;
        n_pop        = r_pop;
        n_res_data   = r_res_data;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        n_out_fill   = r_out_fill;
        ram_we       = 1'b0;
        ram_waddr    = AW'(r_level);
        ram_wdata    = s_axis_tdata;
        ram_raddr    = AW'(r_level - One);
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_val        = s_axis_tdata;
                    n_res_data   = '0;
                    n_res_status = ST_OK;
                    n_pop        = (s_axis_tuser == K_POP);
                    n_full       = 1'b0;
                    n_sort       = 1'b0;
                    n_pos        = r_level;
                    n_lo         = '0;
                    case (s_axis_tuser)
                        K_PUSH: begin
                            if (full_now) begin
                                n_res_status = ST_FULL;
                            end else begin
                                ram_we  = 1'b1;
                                n_level = r_level + One;
                            end
                        end
                        K_POP, K_PEEK: begin
                            if (r_level == '0) begin
                                n_res_data   = EmptyWord;
                                n_res_status = ST_EMPTY;
                            end
                        end
                        K_INSERT: begin
                            n_full = full_now;
                            if (full_now) begin
                                n_res_status = ST_FULL;
                            end
                        end
                        K_SORT: begin
                            n_sort = 1'b1;
                            n_lo   = One;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                n_res_data = ram_rdata;
                if (r_pop) begin
                    n_level = r_level - One;
                end
            end
            S_INS: begin
                // Read data holds the entry just below the hole.
                if (ins_stop) begin
                    ram_we    = !top_drop;
                    ram_waddr = AW'(r_pos);
                    ram_wdata = r_val;
                    if (!r_sort && !r_full) begin
                        n_level = r_level + One;
                    end
                    if (r_sort) begin
                        n_lo = r_lo + One;
                    end
                end else begin
                    ram_we    = !top_drop;
                    ram_waddr = AW'(r_pos);
                    ram_wdata = ram_rdata;
                    n_pos     = r_pos - One;
                    ram_raddr = AW'(r_pos - Two);
                end
            end
            S_SRT_RD: begin
                ram_raddr = AW'(r_lo);
            end
            S_SRT_LD: begin
                n_val     = ram_rdata;
                n_pos     = r_lo;
                ram_raddr = AW'(r_lo - One);
            end
            S_REV_B: begin
                n_val     = ram_rdata;
                ram_raddr = AW'(r_lo);
            end
            S_REV_C: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_pos - One);
                ram_wdata = ram_rdata;
            end
            S_REV_D: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_lo);
                ram_wdata = r_val;
                n_lo      = r_lo + One;
                n_pos     = r_pos - One;
                ram_raddr = AW'(r_pos - Two);
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_data   = r_res_data;
                    n_out_status = r_res_status;
                    n_out_fill   = FillW'(r_level);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_level     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_lo         <= n_lo;
        r_val        <= n_val;
        r_full       <= n_full;
        r_sort       <= n_sort;
        r_pop        <= n_pop;
        r_res_data   <= n_res_data;
        r_res_status <= n_res_status;
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
        r_out_fill   <= n_out_fill;
    end

    `BSOI_ASSERT(a_level_bound, i_clk, i_rst_n, r_level <= LW'(DEPTH), "level exceeds depth")
    `BSOI_ASSERT_IMP(a_hole_bound, i_clk, i_rst_n, r_state == S_INS, r_pos <= r_level,
        "insert hole above level")
    `BSOI_ASSERT(a_level_step, i_clk, i_rst_n,
        (r_level == $past(r_level)) || (r_level == $past(r_level) + One) ||
        (r_level + One == $past(r_level)), "level moved by more than one")
    `BSOI_ASSERT_IMP(a_out_from_fin, i_clk, i_rst_n, r_out_valid && !$past(r_out_valid),
        $past(r_state == S_FIN), "result loaded outside finish")
    `BSOI_ASSERT_IMP(a_waddr_range, i_clk, i_rst_n, ram_we, LW'(ram_waddr) < LW'(DEPTH),
        "memory write out of range")

endmodule
